@@ hdl/knn_push_gradient_defines.svh @@
// Assertion macros for the k-nearest-neighbour gradient block.
// Used by the top level only; no other dependencies.
`ifndef KNN_PUSH_GRADIENT_DEFINES_SVH
`define KNN_PUSH_GRADIENT_DEFINES_SVH

// implication in the same cycle
`define KNP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle
`define KNP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/knp_pkg.sv @@
// Package for the k-nearest-neighbour gradient block: types, constants and
// the fixed-point helpers. No dependencies.
package knp_pkg;

  localparam int DEF_MAX_VERTICES   = 1024;
  localparam int DEF_MAX_FEATURES   = 32;
  localparam int DEF_MAX_NEIGHBOURS = 32;
  localparam int QUEUE_DEPTH        = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_GRAD    = 2'd0,
    ACT_LOAD_SLOT    = 2'd1,
    ACT_LOAD_FEATURE = 2'd2,
    ACT_COMPUTE      = 2'd3
  } action_t;

  typedef enum logic {
    REG_FEATURE_COUNT   = 1'b0,
    REG_NEIGHBOUR_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_FEATURE = 1'b0,
    KIND_WEIGHT  = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    action_t            action;
    logic               row_ok;
    logic               feat_col_ok;
    logic               slot_col_ok;
    logic [9:0]         row;
    logic [4:0]         column;
    logic signed [10:0] neighbour_index;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic     avail;
    request_t req;
  } queue_head_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] to_q16(input logic signed [63:0] v);
    if (!v[63] && (v[62:47] != 16'd0)) begin
      return {1'b0, {31{1'b1}}};
    end
    if (v[63] && (v[62:47] != 16'hFFFF)) begin
      return {1'b1, 31'd0};
    end
    return v[47:16];
  endfunction

  function automatic logic [5:0] clamp_count(input logic [5:0] v, input logic [5:0] lim);
    if (v == 6'd0) begin
      return 6'd1;
    end
    return (v > lim) ? lim : v;
  endfunction

endpackage

@@ hdl/knp_in_if.sv @@
// Request channel of the k-nearest-neighbour gradient block.
// Uses nothing but plain logic.
interface knp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [9:0]         vertex_row;
  logic [4:0]         column;
  logic signed [10:0] neighbour_index;
  logic signed [31:0] sample_value;

  modport source (output valid, action, vertex_row, column, neighbour_index,
                  sample_value, input ready);
  modport sink (input valid, action, vertex_row, column, neighbour_index,
                sample_value, output ready);
endinterface

@@ hdl/knp_out_if.sv @@
// Result channel of the k-nearest-neighbour gradient block.
// Uses nothing but plain logic.
interface knp_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [4:0]         result_position;
  logic signed [31:0] result_value;
  logic               last_of_run;

  modport source (output valid, result_kind, result_position, result_value,
                  last_of_run, input ready);
  modport sink (input valid, result_kind, result_position, result_value,
                last_of_run, output ready);
endinterface

@@ hdl/knp_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on knp_pkg and knp_in_if.
module knp_front #(
  parameter int MAX_VERTICES   = knp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_FEATURES   = knp_pkg::DEF_MAX_FEATURES,
  parameter int MAX_NEIGHBOURS = knp_pkg::DEF_MAX_NEIGHBOURS
) (
  input  logic                 clk,
  input  logic                 rst,
  knp_in_if.sink               items,
  input  logic                 pop,
  output knp_pkg::queue_head_t head,
  output logic [1:0]           fill
);
  import knp_pkg::*;

  request_t   slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  request_t   cls;
  logic       push;

  always_comb begin
    cls.action          = action_t'(items.action);
    cls.row_ok          = 32'(items.vertex_row) < 32'(MAX_VERTICES);
    cls.feat_col_ok     = 32'(items.column) < 32'(MAX_FEATURES);
    cls.slot_col_ok     = 32'(items.column) < 32'(MAX_NEIGHBOURS);
    cls.row             = items.vertex_row;
    cls.column          = items.column;
    cls.neighbour_index = items.neighbour_index;
    cls.value           = items.sample_value;
  end

  assign items.ready = count != 2'(QUEUE_DEPTH);
  assign push        = items.valid && items.ready;
  assign head.avail  = count != 2'd0;
  assign head.req    = slots[rd_ptr];
  assign fill        = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ hdl/knp_back.sv @@
// Back end: carries out loads into the stores and runs the gradient sums.
// Depends on knp_pkg and knp_out_if.
module knp_back #(
  parameter int MAX_VERTICES   = knp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_FEATURES   = knp_pkg::DEF_MAX_FEATURES,
  parameter int MAX_NEIGHBOURS = knp_pkg::DEF_MAX_NEIGHBOURS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  knp_pkg::queue_head_t head,
  output logic                 pop,
  input  logic [5:0]           feature_count,
  input  logic [5:0]           neighbour_count,
  knp_out_if.source            results
);
  import knp_pkg::*;

  localparam int GDEPTH = MAX_VERTICES * MAX_FEATURES;
  localparam int AW     = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int NW     = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

  logic signed [31:0] grad_mem [GDEPTH];
  logic signed [10:0] idx_store [MAX_NEIGHBOURS];
  logic signed [31:0] weight_store [MAX_NEIGHBOURS];
  logic signed [31:0] feature_store [MAX_FEATURES];

  back_state_t        state;
  back_state_t        state_next;
  logic               phase;
  logic [5:0]         outer;
  logic [5:0]         inner;
  logic signed [63:0] acc;
  logic signed [31:0] rd_data;
  logic signed [31:0] s1_op;
  logic               s1_v;
  logic signed [63:0] prod;
  logic               s2_v;
  logic               out_v;
  logic               out_kind;
  logic [4:0]         out_pos;
  logic signed [31:0] out_val;
  logic               out_last;

  logic [5:0]         nf;
  logic [5:0]         nn;
  logic [5:0]         inner_lim;
  logic [5:0]         outer_lim;
  logic [5:0]         n_sel;
  logic [5:0]         f_sel;
  logic signed [10:0] idx_sel;
  logic               slot_ok;
  logic               issue;
  logic               inner_end;
  logic               drained;
  logic               emit;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic               start;

  assign nf        = clamp_count(feature_count, 6'(MAX_FEATURES));
  assign nn        = clamp_count(neighbour_count, 6'(MAX_NEIGHBOURS));
  assign inner_lim = phase ? nf : nn;
  assign outer_lim = phase ? nn : nf;
  assign n_sel     = phase ? outer : inner;
  assign f_sel     = phase ? inner : outer;
  assign idx_sel   = idx_store[n_sel[NW-1:0]];
  assign slot_ok   = !idx_sel[10] && ({22'd0, idx_sel[9:0]} < 32'(MAX_VERTICES));
  assign inner_end = inner == inner_lim - 6'd1;
  assign drained   = !s1_v && !s2_v;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head.avail && head.req.action == ACT_COMPUTE) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (inner_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_v || results.ready) begin
          state_next = (phase && outer == outer_lim - 6'd1) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    issue    = 1'b0;
    emit     = 1'b0;
    start    = 1'b0;
    mem_addr = AW'(32'(idx_sel[9:0]) * MAX_FEATURES + 32'(f_sel));
    unique case (state)
      ST_IDLE: begin
        pop   = head.avail;
        start = head.avail && head.req.action == ACT_COMPUTE;
        if (head.avail && head.req.action == ACT_LOAD_GRAD) begin
          mem_we   = head.req.row_ok && head.req.feat_col_ok;
          mem_addr = AW'(32'(head.req.row) * MAX_FEATURES + 32'(head.req.column));
        end
      end
      ST_ISSUE: issue = slot_ok;
      ST_EMIT:  emit  = !out_v || results.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grad_mem[mem_addr] <= head.req.value;
    end
    rd_data <= grad_mem[mem_addr];
    if (pop && head.req.action == ACT_LOAD_SLOT && head.req.slot_col_ok) begin
      idx_store[head.req.column[NW-1:0]]    <= head.req.neighbour_index;
      weight_store[head.req.column[NW-1:0]] <= head.req.value;
    end
    if (pop && head.req.action == ACT_LOAD_FEATURE && head.req.feat_col_ok) begin
      feature_store[head.req.column[FW-1:0]] <= head.req.value;
    end
    s1_op <= phase ? feature_store[f_sel[FW-1:0]] : weight_store[n_sel[NW-1:0]];
    prod  <= 64'(rd_data) * 64'(s1_op);
    if (emit) begin
      out_kind <= phase;
      out_pos  <= outer[4:0];
      out_val  <= to_q16(acc);
      out_last <= phase && outer == outer_lim - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
      outer <= 6'd0;
      inner <= 6'd0;
      acc   <= '0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      s1_v  <= issue;
      s2_v  <= s1_v;
      if (s2_v) begin
        acc <= sat_add(acc, prod);
      end
      if (start) begin
        phase <= 1'b0;
        outer <= 6'd0;
        inner <= 6'd0;
        acc   <= '0;
      end
      if (state == ST_ISSUE) begin
        inner <= inner + 6'd1;
      end
      if (emit) begin
        inner <= 6'd0;
        acc   <= '0;
        if (outer == outer_lim - 6'd1) begin
          phase <= 1'b1;
          outer <= 6'd0;
        end else begin
          outer <= outer + 6'd1;
        end
      end
      if (emit) begin
        out_v <= 1'b1;
      end else if (results.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  assign results.valid           = out_v;
  assign results.result_kind     = out_kind;
  assign results.result_position = out_pos;
  assign results.result_value    = out_val;
  assign results.last_of_run     = out_last;
endmodule

@@ hdl/knn_push_gradient.sv @@
// Weighted k-nearest-neighbour gather, backward pass. Each load request (gradient
// element, neighbour slot or feature) is carried out while the back end is idle.
// A compute request runs one multiply-accumulate per cycle while issuing,
// through a single gradient memory read port, giving F feature gradients then N
// weight gradients (F, N: feature and neighbour counts), each held until taken.
// Depends on knp_pkg, knp_in_if, knp_out_if, knp_front, knp_back and the defines.
`include "knn_push_gradient_defines.svh"
module knn_push_gradient #(
  parameter int MAX_VERTICES   = knp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_FEATURES   = knp_pkg::DEF_MAX_FEATURES,
  parameter int MAX_NEIGHBOURS = knp_pkg::DEF_MAX_NEIGHBOURS
) (
  input  logic       clk,
  input  logic       rst,
  knp_in_if.sink     items,
  knp_out_if.source  results,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);
  import knp_pkg::*;

  queue_head_t head;
  logic        pop;
  logic [1:0]  fill;
  logic [5:0]  feature_count;
  logic [5:0]  neighbour_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count   <= 6'd32;
      neighbour_count <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FEATURE_COUNT:   feature_count   <= cfg_data;
        REG_NEIGHBOUR_COUNT: neighbour_count <= cfg_data;
        default: ;
      endcase
    end
  end

  knp_front #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_FEATURES(MAX_FEATURES),
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
  ) u_front (
    .clk, .rst, .items, .pop, .head, .fill
  );

  knp_back #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_FEATURES(MAX_FEATURES),
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
  ) u_back (
    .clk, .rst, .head, .pop, .feature_count, .neighbour_count, .results
  );

  `KNP_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= 2'(QUEUE_DEPTH), "queue overfilled")
  `KNP_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, head.avail, "pop from empty queue")
  `KNP_ASSERT_NEXT(a_full_blocks, clk, rst, fill == 2'(QUEUE_DEPTH) && !pop, !items.ready, "full queue took a request")
endmodule
